// ===== hw/rtl/gregorian_date_decode_defines.svh =====
// Assertion macros for the Gregorian date decoder.
`ifndef GREGORIAN_DATE_DECODE_DEFINES_SVH
`define GREGORIAN_DATE_DECODE_DEFINES_SVH

`ifndef ASSERT_OFF
`define GDD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gdd assertion failed");
`define GDD_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("gdd assertion failed");
`else
`define GDD_ASSERT(lbl, clk, rst_n, prop)
`define GDD_ASSERT_NR(lbl, clk, prop)
`endif

`endif

// ===== hw/rtl/gdd_pkg.sv =====
// Types, constants and month table for the Gregorian date decoder.
package gdd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DOY_W   = 9;
  localparam int WD_W    = 3;
  localparam int DN_W    = 22;
  localparam int DBY_W   = 23;
  localparam int WSUM_W  = 15;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  localparam int EPOCH_YEAR = 1582;
  localparam int EPOCH_EFF  = (EPOCH_YEAR < 1) ? 1 : EPOCH_YEAR;
  localparam int EPOCH_P    = EPOCH_EFF - 1;
  localparam int DBY_EPOCH  = 365 * EPOCH_P + EPOCH_P / 4 - EPOCH_P / 100 + EPOCH_P / 400;

  localparam logic [YEAR_W-1:0] EPOCH_Y = YEAR_W'(EPOCH_EFF);
  localparam logic [DBY_W-1:0]  DBY_EP  = DBY_W'(DBY_EPOCH);

  // Reciprocal multipliers: floor(x * R >> S) for x below 2^15
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam logic [14:0] RECIP_25  = 15'd20972;
  localparam int          RECIP_SH  = 19;
  localparam logic [14:0] RECIP_7   = 15'd18725;
  localparam int          RECIP7_SH = 17;

  localparam logic [MONTH_W-1:0] MARCH = 4'd3;

  typedef logic [YEAR_W-1:0]  year_t;
  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [DOY_W-1:0]   doy_t;

  // Days before the given month in a common year
  function automatic doy_t days_before_month(input month_t m);
    doy_t d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      4'd13:   d = 9'd365;
      4'd14:   d = 9'd395;
      default: d = 9'd425;
    endcase
    return d;
  endfunction

endpackage

// ===== hw/rtl/gregorian_date_decode.sv =====
// Gregorian date decoder: leap flag, day of year, weekday and day number.
// Each item passes through the register stages s1, s2, s3 and s4 in order.
// Throughput: one item per cycle while out_tready is high; the four register stages stall in place and
// empty stages fill while the output is held.
// Reset clears the valid bits of all stages; payload registers are not reset.
`include "gregorian_date_decode_defines.svh"

module gregorian_date_decode (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // year[13:0], month[17:14], day[22:18], zero[23]
  input  logic [gdd_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // leap[0], day_of_year[9:1], weekday[12:10], day_number[34:13], zero[39:35]
  output logic [gdd_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import gdd_pkg::*;

  logic en1, en2, en3, en4;
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;

  year_t  in_year;
  month_t in_month;
  day_t   in_day;
  year_t  in_eff;
  year_t  s1_p_nxt;

  year_t       s1_year_r;
  month_t      s1_month_r;
  day_t        s1_day_r;
  year_t       s1_p_r;
  logic [26:0] s1_prod100_r, s1_prod100_nxt;
  logic [24:0] s1_prod400_r, s1_prod400_nxt;
  logic [28:0] s1_prod25_r, s1_prod25_nxt;

  logic [11:0]       s1_q4;
  logic [7:0]        s1_q100;
  logic [5:0]        s1_q400;
  logic [9:0]        s1_q25;
  logic [YEAR_W-1:0] s1_r25;
  logic              s2_leap_nxt;
  doy_t              s2_doy_nxt;
  logic [DBY_W-1:0]  s2_dby_nxt;
  logic [WSUM_W-1:0] s2_wsum_nxt;

  logic              s2_leap_r;
  doy_t              s2_doy_r;
  logic [DBY_W-1:0]  s2_dby_r;
  logic [WSUM_W-1:0] s2_wsum_r;

  logic [DBY_W-1:0]  s3_num_full;
  logic [WSUM_W-1:0] s3_s_nxt;
  logic [28:0]       s3_prod7_nxt;

  logic              s3_leap_r;
  doy_t              s3_doy_r;
  logic [DN_W-1:0]   s3_num_r;
  logic [WSUM_W-1:0] s3_s_r;
  logic [28:0]       s3_prod7_r;

  logic [11:0]       s3_q7;
  logic [WSUM_W-1:0] s4_wd_full;

  logic              s4_leap_r;
  doy_t              s4_doy_r;
  logic [WD_W-1:0]   s4_wd_r;
  logic [DN_W-1:0]   s4_num_r;

  assign en4 = !s4_valid_r || out_tready;
  assign en3 = !s3_valid_r || en4;
  assign en2 = !s2_valid_r || en3;
  assign en1 = !s1_valid_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (en1) s1_valid_r <= in_tvalid;
      if (en2) s2_valid_r <= s1_valid_r;
      if (en3) s3_valid_r <= s2_valid_r;
      if (en4) s4_valid_r <= s3_valid_r;
    end
  end

  // Stage 1: unpack, clamp year, start reciprocal products
  assign in_year  = in_tdata[13:0];
  assign in_month = in_tdata[17:14];
  assign in_day   = in_tdata[22:18];
  assign in_eff   = (in_year > EPOCH_Y) ? in_year : EPOCH_Y;
  assign s1_p_nxt = in_eff - YEAR_W'(1);

  assign s1_prod100_nxt = 27'(s1_p_nxt) * 27'(RECIP_100);
  assign s1_prod400_nxt = 25'(s1_p_nxt[YEAR_W-1:2]) * 25'(RECIP_100);
  assign s1_prod25_nxt  = 29'(in_year) * 29'(RECIP_25);

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_year_r    <= in_year;
      s1_month_r   <= in_month;
      s1_day_r     <= in_day;
      s1_p_r       <= s1_p_nxt;
      s1_prod100_r <= s1_prod100_nxt;
      s1_prod400_r <= s1_prod400_nxt;
      s1_prod25_r  <= s1_prod25_nxt;
    end
  end

  // Stage 2: leap flag, day of year, days before year, partial weekday sum
  assign s1_q4   = s1_p_r[YEAR_W-1:2];
  assign s1_q100 = s1_prod100_r[26:RECIP_SH];
  assign s1_q400 = s1_prod400_r[24:RECIP_SH];
  assign s1_q25  = s1_prod25_r[28:RECIP_SH];
  assign s1_r25  = s1_year_r - YEAR_W'(s1_q25) * YEAR_W'(25);

  assign s2_leap_nxt = ((s1_year_r[1:0] == 2'd0) && (s1_r25 != '0)) ||
                       ((s1_year_r[3:0] == 4'd0) && (s1_r25 == '0));
  assign s2_doy_nxt  = days_before_month(s1_month_r)
                     + DOY_W'(s2_leap_nxt && (s1_month_r >= MARCH))
                     + DOY_W'(s1_day_r);
  assign s2_dby_nxt  = DBY_W'(s1_p_r) * DBY_W'(365) + DBY_W'(s1_q4)
                     + DBY_W'(s1_q400) - DBY_W'(s1_q100);
  assign s2_wsum_nxt = WSUM_W'(s1_p_r) + WSUM_W'(s1_q4)
                     + WSUM_W'(s1_q400) - WSUM_W'(s1_q100);

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_leap_r <= s2_leap_nxt;
      s2_doy_r  <= s2_doy_nxt;
      s2_dby_r  <= s2_dby_nxt;
      s2_wsum_r <= s2_wsum_nxt;
    end
  end

  // Stage 3: day number, weekday sum and its reciprocal product
  assign s3_num_full  = s2_dby_r + DBY_W'(s2_doy_r) - DBY_EP;
  assign s3_s_nxt     = s2_wsum_r + WSUM_W'(s2_doy_r);
  assign s3_prod7_nxt = 29'(s3_s_nxt) * 29'(RECIP_7);

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_leap_r  <= s2_leap_r;
      s3_doy_r   <= s2_doy_r;
      s3_num_r   <= s3_num_full[DN_W-1:0];
      s3_s_r     <= s3_s_nxt;
      s3_prod7_r <= s3_prod7_nxt;
    end
  end

  // Stage 4: remainder by seven, output register
  assign s3_q7      = s3_prod7_r[28:RECIP7_SH];
  assign s4_wd_full = s3_s_r - WSUM_W'(s3_q7) * WSUM_W'(7);

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_leap_r <= s3_leap_r;
      s4_doy_r  <= s3_doy_r;
      s4_wd_r   <= s4_wd_full[WD_W-1:0];
      s4_num_r  <= s3_num_r;
    end
  end

  assign out_tvalid = s4_valid_r;
  assign out_tdata  = {5'd0, s4_num_r, s4_wd_r, s4_doy_r, s4_leap_r};

  `GDD_ASSERT(a_accept_fills_s1, clk, rst_n, (in_tvalid && in_tready) |=> s1_valid_r)
  `GDD_ASSERT(a_s3_stall_holds, clk, rst_n, (s3_valid_r && !en3) |=> $stable(s3_s_r))
  `GDD_ASSERT(a_weekday_range, clk, rst_n, s4_valid_r |-> (s4_wd_r <= 3'd6))
  `GDD_ASSERT_NR(a_reset_empties, clk, !rst_n |=> (!s1_valid_r && !s4_valid_r))

endmodule

// ===== tb/gregorian_date_checker.sv =====
// Checker for the Gregorian date decoder: predicts each decoded date and compares results.
module gregorian_date_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [gdd_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [gdd_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                              errors,
  output int                              pending
);
  import gdd_pkg::*;

  typedef struct packed {
    logic [DN_W-1:0] day_number;
    logic [WD_W-1:0] weekday;
    doy_t            day_of_year;
    logic            leap;
  } date_info_t;

  date_info_t decoded_queue[$];
  int         err_count = 0;

  // days from 0001-01-01 up to Jan 1 of year y
  function automatic int unsigned whole_days(input int unsigned y);
    int unsigned p;
    p = y - 1;
    return 365 * p + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic date_info_t decode_date(input logic [IN_TDATA_W-1:0] word);
    year_t       y;
    month_t      m;
    day_t        d;
    int unsigned eff;
    int unsigned lead;
    int unsigned doy;
    int unsigned total;
    int unsigned num;
    logic        is_leap;
    date_info_t  r;
    y = word[YEAR_W-1:0];
    m = word[YEAR_W+MONTH_W-1:YEAR_W];
    d = word[YEAR_W+MONTH_W+DAY_W-1:YEAR_W+MONTH_W];
    eff = (int'(y) > EPOCH_EFF) ? int'(y) : EPOCH_EFF;
    is_leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      4'd0, 4'd1: lead = 0;
      4'd2:       lead = 31;
      4'd3:       lead = 59;
      4'd4:       lead = 90;
      4'd5:       lead = 120;
      4'd6:       lead = 151;
      4'd7:       lead = 181;
      4'd8:       lead = 212;
      4'd9:       lead = 243;
      4'd10:      lead = 273;
      4'd11:      lead = 304;
      4'd12:      lead = 334;
      4'd13:      lead = 365;
      4'd14:      lead = 395;
      default:    lead = 425;
    endcase
    doy = lead + ((is_leap && m >= 3) ? 1 : 0) + d;
    total = whole_days(eff) + doy;
    num = whole_days(eff) - whole_days(EPOCH_EFF) + doy;
    r.leap        = is_leap;
    r.day_of_year = DOY_W'(doy);
    r.weekday     = WD_W'(total % 7);
    r.day_number  = DN_W'(num);
    return r;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    date_info_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (decoded_queue.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %h", $time, out_tdata);
          err_count++;
        end else begin
          want = decoded_queue.pop_front();
          check_field("leap", 32'(want.leap), 32'(out_tdata[0]));
          check_field("day_of_year", 32'(want.day_of_year), 32'(out_tdata[9:1]));
          check_field("weekday", 32'(want.weekday), 32'(out_tdata[12:10]));
          check_field("day_number", 32'(want.day_number), 32'(out_tdata[34:13]));
          check_field("padding", 32'(0), 32'(out_tdata[OUT_TDATA_W-1:35]));
        end
      end
      if (in_tvalid && in_tready) begin
        decoded_queue.push_back(decode_date(in_tdata));
      end
      pending <= decoded_queue.size();
      errors  <= err_count;
    end
  end

endmodule

// ===== tb/tb_gregorian_date_decode.sv =====
// Testbench top for the Gregorian date decoder: stimulus, flow control and verdict.
module tb_gregorian_date_decode;
  import gdd_pkg::*;

  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_ITEMS = 550;
  localparam int PHASES       = 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 100000;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tready = 1'b0;
  logic                   in_tready;
  logic                   out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_req       = 1'b0;
  int   cycles         = 0;
  int   errors;
  int   pending;

  always #5 clk = ~clk;

  gregorian_date_decode dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    // year[13:0], month[17:14], day[22:18], zero[23]
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // leap[0], day_of_year[9:1], weekday[12:10], day_number[34:13], zero[39:35]
    .out_tdata  (out_tdata)
  );

  gregorian_date_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .errors     (errors),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_date(input year_t y, input month_t m, input day_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, d, m, y};
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    year_t  y;
    month_t m;
    day_t   d;
    int     pick;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_date(14'd1582, 4'd1, 5'd1);
    send_date(14'd1582, 4'd1, 5'd0);
    send_date(14'd0, 4'd1, 5'd1);
    send_date(14'd0, 4'd0, 5'd0);
    send_date(14'd1581, 4'd12, 5'd31);
    send_date(14'd1580, 4'd3, 5'd1);
    send_date(14'd1600, 4'd2, 5'd29);
    send_date(14'd1700, 4'd3, 5'd1);
    send_date(14'd1900, 4'd12, 5'd31);
    send_date(14'd2000, 4'd12, 5'd31);
    send_date(14'd2024, 4'd3, 5'd1);
    send_date(14'd2023, 4'd0, 5'd5);
    send_date(14'd2023, 4'd1, 5'd0);
    send_date(14'd2024, 4'd13, 5'd1);
    send_date(14'd2024, 4'd14, 5'd30);
    send_date(14'd2023, 4'd15, 5'd31);
    send_date(14'd9999, 4'd12, 5'd31);
    send_date(14'd13000, 4'd1, 5'd1);
    send_date(14'd14000, 4'd1, 5'd1);
    send_date(14'd16383, 4'd15, 5'd31);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_req <= 1'b1; end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          y = year_t'($urandom_range(EPOCH_EFF, 9999));
        end else if (pick < 80) begin
          y = year_t'($urandom_range(0, EPOCH_EFF - 1));
        end else if (pick < 90) begin
          y = year_t'($urandom_range(10000, 16383));
        end else begin
          y = year_t'($urandom);
        end
        m = ($urandom_range(99) < 85) ? month_t'($urandom_range(1, 12)) : month_t'($urandom);
        d = ($urandom_range(99) < 90) ? day_t'($urandom_range(1, 31)) : day_t'($urandom);
        send_date(y, m, d);
      end
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
